// File: design/rsdf_pkg.sv
// ---------------------------------------------------------------------------
// rsdf_pkg
// Shared types and codes for the recent share duplicate filter.
// ---------------------------------------------------------------------------
`default_nettype none

package rsdf_pkg;

    localparam int NONCE_W  = 32;
    localparam int JOB_W    = 32;
    localparam int WORKER_W = 8;
    localparam int SHARE_W  = NONCE_W + JOB_W + WORKER_W;

    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 5;
    localparam int RES_W    = 8;
    localparam int RES_PAD  = RES_W - STATUS_W - SLOT_W;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_ACCEPTED  = 2'd0,
        STATUS_DUPLICATE = 2'd1,
        STATUS_INVALID   = 2'd2
    } status_t;

    // one share, nonce in the lowest bits
    typedef struct packed {
        logic [WORKER_W-1:0] worker;
        logic [JOB_W-1:0]    job;
        logic [NONCE_W-1:0]  nonce;
    } share_t;

endpackage

`default_nettype wire

// File: design/recent_share_duplicate_filter.sv
// ---------------------------------------------------------------------------
// recent_share_duplicate_filter
// Drops shares already seen in a ring of recent shares, stores new ones.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one share per beat (nonce, job number, worker id).
//   The m_ channel returns one result per share: a status code and the ring
//   slot a new share was written to.
//   A share with a worker id at or above WORKER_LIMIT is answered as invalid
//   without a ring scan. Any other share is compared against the
//   ring, one entry per cycle read from a single-port memory with registered
//   read data, so a new share is compared with every entry before its result
//   is set; a duplicate finishes as soon as the matching entry is compared.
//   One share is in work at a time: s_tready is high only while no share is
//   being checked. The result sits in an output register, so the next share
//   is taken while a result still waits for m_tready; a stalled receiver
//   holds the following result back in the block until the register frees.
//   Reset clears the valid bits of all ring entries, the write pointer and
//   the result valid; the ring contents themselves are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module recent_share_duplicate_filter #(
    parameter int RING_DEPTH   = 32,
    parameter int WORKER_LIMIT = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // nonce[31:0], job_number[63:32], worker_id[71:64]
    input  logic [rsdf_pkg::SHARE_W-1:0] s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // status[1:0], slot_written[6:2], zero[7]
    output logic [rsdf_pkg::RES_W-1:0] m_tdata
);

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(RING_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                              state_reg, state_next;
    rsdf_pkg::share_t                    share_reg, share_next;
    rsdf_pkg::share_t                    s_share;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic                                cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]                    cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]                    wp_reg, wp_next;
    logic [RING_DEPTH-1:0]               valid_reg;
    rsdf_pkg::status_t                   res_status_reg, res_status_next;
    logic [rsdf_pkg::SLOT_W-1:0]         res_slot_reg, res_slot_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [rsdf_pkg::RES_W-1:0]          m_tdata_reg, m_tdata_next;

    rsdf_pkg::share_t                    ring_mem [RING_DEPTH];
    rsdf_pkg::share_t                    rd_data_reg;
    logic                                mem_re, mem_we;
    logic [IDX_W-1:0]                    rd_addr;

    logic                                hit;
    logic                                out_free;
    logic [IDX_W+rsdf_pkg::SLOT_W-1:0]   wp_ext;

    assign s_share  = rsdf_pkg::share_t'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign rd_addr  = cnt_reg[IDX_W-1:0];
    assign hit      = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_data_reg == share_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    // slot field carries the low bits of the pointer
    assign wp_ext   = {{rsdf_pkg::SLOT_W{1'b0}}, wp_reg};

    always_comb begin
        state_next      = state_reg;
        share_next      = share_reg;
        cnt_next        = cnt_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        wp_next         = wp_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    share_next = s_share;
                    if (s_share.worker >= rsdf_pkg::WORKER_W'(WORKER_LIMIT)) begin
                        res_status_next = rsdf_pkg::STATUS_INVALID;
                        res_slot_next   = '0;
                        state_next      = ST_DONE;
                    end else begin
                        cnt_next     = '0;
                        cmp_vld_next = 1'b0;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // read stage: one entry per cycle
                if (cnt_reg != CNT_END) begin
                    mem_re       = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_addr;
                    cnt_next     = cnt_reg + 1'b1;
                end else begin
                    cmp_vld_next = 1'b0;
                end
                // compare stage, in the cycle after the read
                if (hit) begin
                    res_status_next = rsdf_pkg::STATUS_DUPLICATE;
                    res_slot_next   = '0;
                    cmp_vld_next    = 1'b0;
                    state_next      = ST_DONE;
                end else if (cmp_vld_reg && (cmp_idx_reg == IDX_LAST)) begin
                    mem_we          = 1'b1;
                    res_status_next = rsdf_pkg::STATUS_ACCEPTED;
                    res_slot_next   = wp_ext[rsdf_pkg::SLOT_W-1:0];
                    wp_next         = (wp_reg == IDX_LAST) ? '0 : IDX_W'(wp_reg + 1'b1);
                    cmp_vld_next    = 1'b0;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{rsdf_pkg::RES_PAD{1'b0}}, res_slot_reg, res_status_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            wp_reg       <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            cmp_vld_reg  <= cmp_vld_next;
            wp_reg       <= wp_next;
            m_tvalid_reg <= m_tvalid_next;
            if (mem_we) begin
                valid_reg[wp_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        share_reg      <= share_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // ring storage, single port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[wp_reg] <= share_reg;
        end
        if (mem_re) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/rsdf_checker.sv
// ---------------------------------------------------------------------------
// rsdf_checker
// Port-level checks for the recent share duplicate filter.
// ---------------------------------------------------------------------------
`default_nettype none

module rsdf_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [rsdf_pkg::RES_W-1:0]   m_tdata
);

    // a result beat held back keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // only accepted shares carry a slot
    a_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != rsdf_pkg::STATUS_ACCEPTED) |-> m_tdata[6:2] == 5'd0)
        else $error("slot set on a rejected share");

    // one share in work at a time
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second share taken while one is in work");

    // no result right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat out of reset");

endmodule

bind recent_share_duplicate_filter rsdf_checker u_rsdf_checker (.*);

`default_nettype wire
